@@ rtl/rar_pkg.sv @@
// Package for the rational arithmetic reducer: payload word types, operation codes
// and sequencer states. No dependencies.
package rar_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 2 * OPERAND_WIDTH + 1;
    localparam int DEN_W = 2 * OPERAND_WIDTH - 1;
    localparam int MAG_W = 2 * OPERAND_WIDTH;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]                    kind;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } in_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_equal;
        logic                    undefined;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

endpackage

@@ rtl/rational_arith_reduce.sv @@
// Top level of the rational arithmetic reducer.
// Depends on rar_pkg and rar_divider.
//
// Takes one word of two fractions and an operation, forms the cross products
// with one shared multiplier in the states MUL1, MUL2 and CHECK, reduces by the
// greatest common divisor found with a Euclidean loop whose remainders come from
// the shared bit-serial divider, and then divides numerator and denominator by
// it with the same divider. An undefined operand or an unknown operation ends
// the item after MUL1; a compare, a zero result denominator or a zero
// numerator ends it after CHECK, with no reduction. A new word is taken as soon
// as the previous result sits in the output register; the block waits in its
// last step while that register is still full.
module rational_arith_reduce
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rar_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rar_pkg::out_word_t out_data
);

    localparam int OW = rar_pkg::OPERAND_WIDTH;
    localparam int PW = 2 * OW + 1;

    rar_pkg::state_t state_reg, state_next;

    logic [2:0]                     kind_reg;
    logic signed [OW-1:0]           an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]           p0_reg, p1_reg;
    logic signed [PW-1:0]           p0_next, p1_next;
    logic [rar_pkg::MAG_W-1:0]      x_reg, y_reg, nm_reg, dm_reg;
    logic [rar_pkg::MAG_W-1:0]      x_next, y_next, nm_next, dm_next;
    logic                           neg_reg, neg_next;
    rar_pkg::out_word_t             res_reg, res_next;
    logic                           out_valid_reg;

    logic signed [OW-1:0]           mul_a, mul_b;
    logic signed [2*OW-1:0]         mul_p;
    logic signed [PW-1:0]           n_val;
    logic                           div_start;
    logic [rar_pkg::MAG_W-1:0]      div_dvd, div_dsr, div_q, rem_val;
    logic                           div_done;
    logic                           div_wait_reg, div_wait_next;

    rar_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (rem_val)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            rar_pkg::ST_MUL1:
            begin
                mul_a = an_reg;
                mul_b = (kind_reg == rar_pkg::KIND_MUL) ? bn_reg : bd_reg;
            end
            rar_pkg::ST_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (kind_reg == rar_pkg::KIND_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    always_comb
    begin
        case (kind_reg)
            rar_pkg::KIND_ADD: n_val = p0_reg + p1_reg;
            rar_pkg::KIND_SUB: n_val = p0_reg - p1_reg;
            default:           n_val = p0_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rar_pkg::ST_IDLE:
                if (in_valid)
                    state_next = rar_pkg::ST_MUL1;
            rar_pkg::ST_MUL1:
                if (kind_reg > rar_pkg::KIND_CMP || ad_reg == '0 || bd_reg == '0)
                    state_next = rar_pkg::ST_DONE;
                else
                    state_next = rar_pkg::ST_MUL2;
            rar_pkg::ST_MUL2:
                state_next = rar_pkg::ST_CHECK;
            rar_pkg::ST_CHECK:
                if (kind_reg == rar_pkg::KIND_CMP || mul_p == '0 || n_val == '0)
                    state_next = rar_pkg::ST_DONE;
                else
                    state_next = rar_pkg::ST_GCD;
            rar_pkg::ST_GCD:
                if (div_wait_reg && div_done && rem_val == '0)
                    state_next = rar_pkg::ST_DIVN;
            rar_pkg::ST_DIVN:
                if (div_wait_reg && div_done)
                    state_next = rar_pkg::ST_DIVD;
            rar_pkg::ST_DIVD:
                if (div_wait_reg && div_done)
                    state_next = rar_pkg::ST_DONE;
            rar_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = rar_pkg::ST_IDLE;
            default:
                state_next = rar_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        nm_next       = nm_reg;
        dm_next       = dm_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        div_start     = 1'b0;
        div_dvd       = x_reg;
        div_dsr       = y_reg;
        div_wait_next = div_wait_reg;
        case (state_reg)
            rar_pkg::ST_MUL1:
            begin
                p0_next  = PW'(mul_p);
                res_next = '0;
                if (kind_reg > rar_pkg::KIND_CMP || ad_reg == '0 || bd_reg == '0)
                    res_next.undefined = 1'b1;
            end
            rar_pkg::ST_MUL2:
            begin
                p1_next = PW'(mul_p);
            end
            rar_pkg::ST_CHECK:
            begin
                // The denominator product is formed here, reusing the multiplier.
                if (kind_reg == rar_pkg::KIND_CMP)
                    res_next.is_equal = (p0_reg == p1_reg);
                else if (PW'(mul_p) == '0)
                    res_next.undefined = 1'b1;
                else if (n_val == '0)
                    res_next.res_den = rar_pkg::DEN_W'(1);
                else
                begin
                    neg_next      = n_val[PW-1] ^ mul_p[2*OW-1];
                    nm_next       = rar_pkg::MAG_W'(n_val[PW-1] ? -n_val : n_val);
                    dm_next       = rar_pkg::MAG_W'(mul_p[2*OW-1] ? -mul_p : mul_p);
                    x_next        = nm_next;
                    y_next        = dm_next;
                    div_wait_next = 1'b0;
                end
            end
            rar_pkg::ST_GCD:
            begin
                if (!div_wait_reg)
                begin
                    div_start     = 1'b1;
                    div_wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_wait_next = 1'b0;
                    if (rem_val == '0)
                        x_next = y_reg;
                    else
                    begin
                        x_next = y_reg;
                        y_next = rem_val;
                    end
                end
            end
            rar_pkg::ST_DIVN:
            begin
                div_dvd = nm_reg;
                if (!div_wait_reg)
                begin
                    div_start     = 1'b1;
                    div_wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_wait_next = 1'b0;
                    res_next.res_num = neg_reg ? -rar_pkg::NUM_W'(div_q)
                                               : rar_pkg::NUM_W'(div_q);
                end
            end
            rar_pkg::ST_DIVD:
            begin
                div_dvd = dm_reg;
                if (!div_wait_reg)
                begin
                    div_start     = 1'b1;
                    div_wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_wait_next    = 1'b0;
                    res_next.res_den = rar_pkg::DEN_W'(div_q);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rar_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            div_wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_wait_reg <= div_wait_next;
            if (state_reg == rar_pkg::ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rar_pkg::ST_IDLE && in_valid)
        begin
            kind_reg <= in_data.kind;
            an_reg   <= OW'(in_data.a_num);
            ad_reg   <= OW'(in_data.a_den);
            bn_reg   <= OW'(in_data.b_num);
            bd_reg   <= OW'(in_data.b_den);
        end
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        if (state_reg == rar_pkg::ST_DONE && (!out_valid_reg || out_ready))
            out_data <= res_reg;
    end

    assign in_ready  = (state_reg == rar_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    a_div_only_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == rar_pkg::ST_GCD || state_reg == rar_pkg::ST_DIVN
                       || state_reg == rar_pkg::ST_DIVD))
        else $error("divider started outside the reduction steps");

    a_undef_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.undefined) |-> (out_data.res_den == '0 && !out_data.is_equal))
        else $error("undefined result carries a denominator or equality");

    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rar_pkg::ST_DONE && !out_valid_reg) |=> state_reg == rar_pkg::ST_IDLE)
        else $error("finished result not handed to the output register");

endmodule

@@ rtl/rar_divider.sv @@
// Restoring bit-serial divider of 32-bit magnitudes, one quotient bit per cycle.
// Depends on rar_pkg for the magnitude width.
module rar_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rar_pkg::MAG_W-1:0] dividend,
    input  logic [rar_pkg::MAG_W-1:0] divisor,
    output logic                      done,
    output logic [rar_pkg::MAG_W-1:0] quotient,
    output logic [rar_pkg::MAG_W-1:0] remainder
);

    localparam int CW = $clog2(rar_pkg::MAG_W + 1);

    logic [rar_pkg::MAG_W-1:0] quo_reg, quo_next;
    logic [rar_pkg::MAG_W-1:0] rem_reg, rem_next;
    logic [rar_pkg::MAG_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [rar_pkg::MAG_W:0]   trial;
    logic [rar_pkg::MAG_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[rar_pkg::MAG_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(rar_pkg::MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[rar_pkg::MAG_W])
            begin
                rem_next = diff[rar_pkg::MAG_W-1:0];
                quo_next = {quo_reg[rar_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rar_pkg::MAG_W-1:0];
                quo_next = {quo_reg[rar_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ tb/tb_rational_arith_reduce.sv @@
// Testbench for rational_arith_reduce: random and directed fraction words checked
// against an exact behavioural predictor. Depends on rar_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rational_arith_reduce;

    localparam int LIMIT_CYCLES = 10000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    rar_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    rar_pkg::out_word_t out_data;

    rar_pkg::in_word_t  pending_words[$];
    rar_pkg::out_word_t expected_fracs[$];
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_off_cycles;
    int                 cycle_count;
    int                 error_count;
    bit                 stimulus_done;

    // Registers whether the word on the bus was taken at the last rising edge.
    logic               in_ready_seen;

    rational_arith_reduce dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact reduced result of one word.
    function automatic rar_pkg::out_word_t reduce_fraction(rar_pkg::in_word_t w);
        rar_pkg::out_word_t r;
        longint             an, ad, bn, bd, n, d;
        longint unsigned    nm, dm, g;
        bit                 neg;
        an = w.a_num;
        ad = w.a_den;
        bn = w.b_num;
        bd = w.b_den;
        r = '0;
        if (w.kind > rar_pkg::KIND_CMP || ad == 0 || bd == 0)
        begin
            r.undefined = 1'b1;
            return r;
        end
        case (w.kind)
            rar_pkg::KIND_ADD:
            begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            rar_pkg::KIND_SUB:
            begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            rar_pkg::KIND_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            rar_pkg::KIND_DIV:
            begin
                n = an * bd;
                d = ad * bn;
            end
            default:
            begin
                r.is_equal = (an * bd == bn * ad);
                return r;
            end
        endcase
        if (d == 0)
        begin
            r.undefined = 1'b1;
            return r;
        end
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        r.res_num = rar_pkg::NUM_W'(neg ? -longint'(nm) : longint'(nm));
        r.res_den = dm[rar_pkg::DEN_W-1:0];
        return r;
    endfunction

    function automatic rar_pkg::in_word_t make_word(logic [2:0] k, int an, int ad, int bn,
                                                    int bd);
        rar_pkg::in_word_t w;
        w.kind = k;
        w.a_num = an[15:0];
        w.a_den = ad[15:0];
        w.b_num = bn[15:0];
        w.b_den = bd[15:0];
        return w;
    endfunction

    // Mostly small operands so reductions are non-trivial; some full-range values.
    function automatic logic [15:0] rand_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'($signed($urandom_range(0, 40)) - 20);
        else if (sel < 6)
            return 16'($signed($urandom_range(0, 2000)) - 1000);
        else if (sel == 6)
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        else
            return 16'($urandom);
    endfunction

    function automatic rar_pkg::in_word_t rand_word();
        rar_pkg::in_word_t w;
        w.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
        w.a_num = rand_operand();
        w.a_den = rand_operand();
        w.b_num = rand_operand();
        w.b_den = rand_operand();
        // Occasionally make a compare of genuinely equal fractions.
        if (w.kind == rar_pkg::KIND_CMP && $urandom_range(0, 1))
        begin
            w.b_num = 16'(w.a_num * 3);
            w.b_den = 16'(w.a_den * 3);
        end
        return w;
    endfunction

    // Driver: inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_ready_seen))
        begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        if (hold_off_cycles > 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Counts down a long receiver hold-off.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // Monitor: sample at the rising edge.
    always @(posedge clk)
    begin
        in_ready_seen <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (in_valid && in_ready)
                expected_fracs.push_back(reduce_fraction(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_fracs.size() == 0)
                begin
                    $error("unexpected result word %h", out_data);
                    error_count <= error_count + 1;
                end
                else
                begin
                    rar_pkg::out_word_t e;
                    e = expected_fracs.pop_front();
                    if (out_data.res_num !== e.res_num)
                        $error("res_num expected %0d got %0d", e.res_num, out_data.res_num);
                    if (out_data.res_den !== e.res_den)
                        $error("res_den expected %0d got %0d", e.res_den, out_data.res_den);
                    if (out_data.is_equal !== e.is_equal)
                        $error("is_equal expected %0b got %0b", e.is_equal, out_data.is_equal);
                    if (out_data.undefined !== e.undefined)
                        $error("undefined expected %0b got %0b", e.undefined,
                               out_data.undefined);
                    if (out_data !== e)
                        error_count <= error_count + 1;
                end
            end
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_fracs.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_ready_seen = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        error_count = 0;
        stimulus_done = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: every kind, extremes, zero denominators, divide by zero.
        pending_words.push_back(make_word(rar_pkg::KIND_ADD, 1, 2, 1, 3));
        pending_words.push_back(make_word(rar_pkg::KIND_SUB, 1, 2, 1, 2));
        pending_words.push_back(make_word(rar_pkg::KIND_MUL, -4, 6, 3, -8));
        pending_words.push_back(make_word(rar_pkg::KIND_DIV, 2, 3, 4, 9));
        pending_words.push_back(make_word(rar_pkg::KIND_CMP, 1, 2, -2, -4));
        pending_words.push_back(make_word(rar_pkg::KIND_CMP, 1, 2, 2, 3));
        pending_words.push_back(make_word(rar_pkg::KIND_ADD, 1, 0, 1, 1));
        pending_words.push_back(make_word(rar_pkg::KIND_CMP, 1, 1, 1, 0));
        pending_words.push_back(make_word(rar_pkg::KIND_DIV, 5, 7, 0, 3));
        pending_words.push_back(make_word(rar_pkg::KIND_MUL, 0, 7, 5, 3));
        pending_words.push_back(make_word(3'd5, 1, 1, 1, 1));
        pending_words.push_back(make_word(3'd7, 1, 1, 1, 1));
        pending_words.push_back(make_word(rar_pkg::KIND_ADD, -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(rar_pkg::KIND_SUB, 32767, -32768, -32768, 32767));
        pending_words.push_back(make_word(rar_pkg::KIND_MUL, -32768, 1, -32768, -1));
        pending_words.push_back(make_word(rar_pkg::KIND_DIV, -32768, 32767, -1, -32768));
        pending_words.push_back(make_word(rar_pkg::KIND_ADD, 32767, 32767, 32767, 32767));
        pending_words.push_back(make_word(rar_pkg::KIND_CMP, -32768, -32768, 32767, 32767));
        pending_words.push_back(make_word(rar_pkg::KIND_SUB, -1, -1, -1, -1));
        pending_words.push_back(make_word(rar_pkg::KIND_DIV, 65535, 65535, 0, 0));
        drain();

        // Long receiver hold-off while the sender keeps offering words.
        for (int i = 0; i < 20; i++)
            pending_words.push_back(rand_word());
        hold_off_cycles = 3000;
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 245; i++)
                pending_words.push_back(rand_word());
            drain();
        end

        repeat (600) @(posedge clk);
        stimulus_done = 1'b1;
        if (error_count == 0)
            $display("rational_arith_reduce: match");
        else
            $display("rational_arith_reduce: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!stimulus_done && cycle_count > LIMIT_CYCLES)
        begin
            $display("rational_arith_reduce: mismatch");
            $finish;
        end
    end

endmodule
